// File: src/pctd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pctd_pkg
// Shared field widths, result codes and controller/datapath interface types
// for the prefix code table decoder.
// ----------------------------------------------------------------------------
package pctd_pkg;

    localparam int SYM_W  = 8;
    localparam int CODE_W = 32;
    localparam int LEN_W  = 6;
    localparam int STAT_W = 2;
    localparam int WORD_W = SYM_W + CODE_W + LEN_W;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_BIT  = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_MATCHED  = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_LOADED   = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef struct packed {
        logic accept_load;
        logic accept_bit;
        logic scan;
        logic set_hit;
        logic set_ovf;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic hit;
        logic scan_end;
        logic prefix_full;
        logic out_free;
    } t_stat;

    function automatic logic [CODE_W-1:0] mask_code(input logic [CODE_W-1:0] code,
                                                    input logic [LEN_W-1:0]  len);
        logic [CODE_W-1:0] mask;
        if (len >= LEN_W'(CODE_W)) begin
            mask = '1;
        end else begin
            mask = (CODE_W'(1) << len) - CODE_W'(1);
        end
        return code & mask;
    endfunction

endpackage

// File: src/prefix_code_table_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prefix_code_table_decoder_unit
// Prefix code decoder with a loadable code table, newest entry wins.
// ----------------------------------------------------------------------------
// A load beat (action 0) appends one entry to the code table. Its result,
// status loaded or table full, is written to the pending result and then
// to the output register once that is free. A bit beat (action 1) shifts
// one bit into the prefix. It then scans the table newest first through
// the single read port of the code memory, one entry per cycle, with a
// registered read ahead of the compare. o_stall stays high from a taken
// beat until the block is idle again: through the whole scan for a bit
// beat with no result, and up to the hand-off to the output register for
// an overflow or a match. A match ends the scan early. A result that finds
// the output register full and stalled waits until it is free. The table
// needs no clearing after reset; entries are only read below the fill
// count. A finished result waits in the output register while the next beat is taken.
module prefix_code_table_decoder_unit #(
    parameter int TABLE_ENTRIES = 256,
    parameter int MAX_CODE_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_action,
    input  logic [pctd_pkg::SYM_W-1:0]   i_load_symbol,
    input  logic [pctd_pkg::CODE_W-1:0]  i_load_code,
    input  logic [pctd_pkg::LEN_W-1:0]   i_load_length,
    input  logic                         i_code_bit,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [pctd_pkg::SYM_W-1:0]   o_symbol,
    output logic [pctd_pkg::STAT_W-1:0]  o_status
);
    import pctd_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    pctd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_action(i_action),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_stall (o_stall)
    );

    pctd_dpath #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .MAX_CODE_BITS(MAX_CODE_BITS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_load_symbol(i_load_symbol),
        .i_load_code  (i_load_code),
        .i_load_length(i_load_length),
        .i_code_bit   (i_code_bit),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_symbol     (o_symbol),
        .o_status     (o_status)
    );

endmodule

// File: src/pctd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pctd_ctrl
// Sequencer for the decoder: takes a beat, runs the table scan for bit
// beats and hands the result to the output register.
// ----------------------------------------------------------------------------
module pctd_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_action,
    input  pctd_pkg::t_stat i_stat,
    output pctd_pkg::t_cmd  o_cmd,
    output logic            o_stall
);
    import pctd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_action == ACT_LOAD) begin
                        o_cmd.accept_load = 1'b1;
                        n_state = S_EMIT;
                    end else begin
                        o_cmd.accept_bit = 1'b1;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.hit) begin
                    o_cmd.set_hit = 1'b1;
                    n_state = S_EMIT;
                end else if (i_stat.scan_end) begin
                    if (i_stat.prefix_full) begin
                        o_cmd.set_ovf = 1'b1;
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_stall = (r_state != S_IDLE);

endmodule

// File: src/pctd_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pctd_dpath
// Code table memory, entry count, prefix accumulator, scan address with
// registered read and compare, pending result and output register.
// ----------------------------------------------------------------------------
module pctd_dpath #(
    parameter int TABLE_ENTRIES = 256,
    parameter int MAX_CODE_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  pctd_pkg::t_cmd               i_cmd,
    output pctd_pkg::t_stat              o_stat,
    input  logic [pctd_pkg::SYM_W-1:0]   i_load_symbol,
    input  logic [pctd_pkg::CODE_W-1:0]  i_load_code,
    input  logic [pctd_pkg::LEN_W-1:0]   i_load_length,
    input  logic                         i_code_bit,
    input  logic                         i_stall,
    output logic                         o_valid,
    output logic [pctd_pkg::SYM_W-1:0]   o_symbol,
    output logic [pctd_pkg::STAT_W-1:0]  o_status
);
    import pctd_pkg::*;

    localparam int AW   = $clog2(TABLE_ENTRIES);
    localparam int CNTW = $clog2(TABLE_ENTRIES + 1);
    localparam int PLW  = $clog2(MAX_CODE_BITS + 1);
    localparam int LW   = (PLW > LEN_W) ? PLW : LEN_W;
    localparam int XW   = (MAX_CODE_BITS > CODE_W) ? MAX_CODE_BITS : CODE_W;

    logic [WORD_W-1:0]        r_mem [TABLE_ENTRIES];
    logic [WORD_W-1:0]        r_rd_word;
    logic                     r_rd_pend;
    logic [CNTW-1:0]          r_addr;
    logic [CNTW-1:0]          r_count;
    logic [MAX_CODE_BITS-1:0] r_prefix;
    logic [PLW-1:0]           r_plen;
    logic [SYM_W-1:0]         r_pend_sym;
    t_status                  r_pend_status;
    logic                     r_out_valid;
    logic [SYM_W-1:0]         r_out_sym;
    t_status                  r_out_status;

    logic              w_full;
    logic [WORD_W-1:0] w_wr_word;
    logic              w_rd_en;
    logic [CNTW-1:0]   n_addr;
    logic [SYM_W-1:0]  w_rd_sym;
    logic [CODE_W-1:0] w_rd_code;
    logic [LEN_W-1:0]  w_rd_len;
    logic              w_hit;
    logic              w_out_take;

    assign w_full    = (r_count == CNTW'(TABLE_ENTRIES));
    assign w_wr_word = {i_load_symbol, mask_code(i_load_code, i_load_length), i_load_length};
    assign w_rd_en   = i_cmd.scan && (r_addr != '0);
    assign n_addr    = r_addr - 1'b1;
    assign {w_rd_sym, w_rd_code, w_rd_len} = r_rd_word;

    assign w_hit = r_rd_pend && (LW'(w_rd_len) == LW'(r_plen))
                   && (XW'(w_rd_code) == XW'(r_prefix));

    assign w_out_take = r_out_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept_load && !w_full) begin
            r_mem[r_count[AW-1:0]] <= w_wr_word;
        end
        if (w_rd_en) begin
            r_rd_word <= r_mem[n_addr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_prefix  <= '0;
            r_plen    <= '0;
            r_addr    <= '0;
            r_rd_pend <= 1'b0;
        end else begin
            if (i_cmd.accept_load && !w_full) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.accept_bit) begin
                r_prefix  <= {r_prefix[MAX_CODE_BITS-2:0], i_code_bit};
                r_plen    <= (r_plen == PLW'(MAX_CODE_BITS)) ? r_plen : r_plen + 1'b1;
                r_addr    <= r_count;
                r_rd_pend <= 1'b0;
            end else if (i_cmd.set_hit || i_cmd.set_ovf) begin
                r_prefix  <= '0;
                r_plen    <= '0;
                r_rd_pend <= 1'b0;
            end else if (i_cmd.scan) begin
                r_rd_pend <= w_rd_en;
                if (w_rd_en) begin
                    r_addr <= n_addr;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept_load) begin
            r_pend_sym    <= '0;
            r_pend_status <= w_full ? ST_FULL : ST_LOADED;
        end else if (i_cmd.set_hit) begin
            r_pend_sym    <= w_rd_sym;
            r_pend_status <= ST_MATCHED;
        end else if (i_cmd.set_ovf) begin
            r_pend_sym    <= '0;
            r_pend_status <= ST_OVERFLOW;
        end
        if (i_cmd.emit) begin
            r_out_sym    <= r_pend_sym;
            r_out_status <= r_pend_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (w_out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.hit         = w_hit;
    assign o_stat.scan_end    = !r_rd_pend && (r_addr == '0);
    assign o_stat.prefix_full = (r_plen == PLW'(MAX_CODE_BITS));
    assign o_stat.out_free    = !r_out_valid || !i_stall;

    assign o_valid  = r_out_valid;
    assign o_symbol = r_out_sym;
    assign o_status = r_out_status;

`ifndef SYNTHESIS
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || !i_stall))
        else $error("result written over an undelivered beat");
    a_hit_ovf_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.set_hit && i_cmd.set_ovf))
        else $error("match and overflow in the same cycle");
    a_prefix_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.set_hit || i_cmd.set_ovf) |=> (r_plen == '0 && r_prefix == '0))
        else $error("prefix not cleared after a result");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNTW'(TABLE_ENTRIES))
        else $error("entry count beyond table size");
    a_sym_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != ST_MATCHED) |-> (r_out_sym == '0))
        else $error("nonzero symbol on a status beat");
`endif

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for prefix_code_table_decoder_unit. Loads code table
// entries and streams code bits with random gaps and output stalls, keeps a
// mirror of the table and prefix accumulator to predict each result, and
// checks every result beat in order.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic [pctd_pkg::SYM_W-1:0] symbol;
    pctd_pkg::t_status          status;
} t_decode_result;

class decode_scoreboard;
    int unsigned                   table_depth;
    int unsigned                   max_bits;
    logic [pctd_pkg::SYM_W-1:0]    sym_tab[];
    logic [pctd_pkg::CODE_W-1:0]   code_tab[];
    logic [pctd_pkg::LEN_W-1:0]    len_tab[];
    int unsigned                   fill;
    logic [pctd_pkg::CODE_W-1:0]   acc;
    int unsigned                   acc_len;
    t_decode_result                pending_q[$];
    int                            errors;

    function new(int unsigned depth, int unsigned bits);
        table_depth = depth;
        max_bits    = bits;
        sym_tab     = new[depth];
        code_tab    = new[depth];
        len_tab     = new[depth];
        fill        = 0;
        acc         = '0;
        acc_len     = 0;
        errors      = 0;
    endfunction

    function logic [pctd_pkg::CODE_W-1:0] low_bits(int unsigned n);
        logic [63:0] m;
        m = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
        return m[pctd_pkg::CODE_W-1:0];
    endfunction

    function void note_beat(logic act, logic [pctd_pkg::SYM_W-1:0] sym,
                            logic [pctd_pkg::CODE_W-1:0] code,
                            logic [pctd_pkg::LEN_W-1:0] len, logic cbit);
        t_decode_result r;
        r.symbol = '0;
        if (act == pctd_pkg::ACT_LOAD) begin
            if (fill >= table_depth) begin
                r.status = pctd_pkg::ST_FULL;
            end else begin
                sym_tab[fill]  = sym;
                code_tab[fill] = code & low_bits(len);
                len_tab[fill]  = len;
                fill++;
                r.status = pctd_pkg::ST_LOADED;
            end
            pending_q.push_back(r);
            return;
        end
        acc = ((acc << 1) | cbit) & low_bits(max_bits);
        if (acc_len < max_bits) acc_len++;
        for (int k = int'(fill) - 1; k >= 0; k--) begin
            if (len_tab[k] == acc_len && code_tab[k] == acc) begin
                r.symbol = sym_tab[k];
                r.status = pctd_pkg::ST_MATCHED;
                pending_q.push_back(r);
                acc     = '0;
                acc_len = 0;
                return;
            end
        end
        if (acc_len >= max_bits) begin
            r.status = pctd_pkg::ST_OVERFLOW;
            pending_q.push_back(r);
            acc     = '0;
            acc_len = 0;
        end
    endfunction

    task report(string msg);
        errors++;
        if (errors <= 100) $display("MISMATCH %0d: %s", errors, msg);
    endtask

    task check_result(logic [pctd_pkg::SYM_W-1:0] sym, logic [pctd_pkg::STAT_W-1:0] stat);
        t_decode_result want;
        if (pending_q.size() == 0) begin
            report($sformatf("unexpected result symbol %02h status %0d", sym, stat));
            return;
        end
        want = pending_q.pop_front();
        if (stat !== want.status)
            report($sformatf("status %0d, want %0d", stat, want.status));
        if (sym !== want.symbol)
            report($sformatf("symbol %02h, want %02h", sym, want.symbol));
    endtask
endclass

module testbench;

    localparam int TABLE_SIZE     = 256;
    localparam int MAX_BITS       = 32;
    localparam int TOTAL_BEATS    = 1950;
    localparam int TAIL_BEATS     = 120;
    localparam int PRESSURE_AT    = 700;
    localparam int HOLD_CYCLES    = 3000;
    localparam int DRAIN_CYCLES   = 600;
    localparam int WATCHDOG_LIMIT = 20000;

    logic                          i_clk         = 1'b0;
    logic                          i_rst_n       = 1'b0;
    logic                          i_valid       = 1'b0;
    logic                          o_stall;
    logic                          i_action      = 1'b0;
    logic [pctd_pkg::SYM_W-1:0]    i_load_symbol = '0;
    logic [pctd_pkg::CODE_W-1:0]   i_load_code   = '0;
    logic [pctd_pkg::LEN_W-1:0]    i_load_length = '0;
    logic                          i_code_bit    = 1'b0;
    logic                          o_valid;
    logic                          i_stall       = 1'b0;
    logic [pctd_pkg::SYM_W-1:0]    o_symbol;
    logic [pctd_pkg::STAT_W-1:0]   o_status;

    decode_scoreboard sb;
    int  beats_sent    = 0;
    int  idle_cycles   = 0;
    bit  src_gappy     = 1'b1;
    bit  src_quiet     = 1'b0;
    bit  hold_req      = 1'b0;
    bit  pressure_done = 1'b0;

    prefix_code_table_decoder_unit #(
        .TABLE_ENTRIES (TABLE_SIZE),
        .MAX_CODE_BITS (MAX_BITS)
    ) i_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_result(o_symbol, o_status);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // result side: random stall bursts, one long hold-off on request
    initial begin
        int mode_left;
        bit gappy;
        mode_left = 0;
        gappy     = 1'b0;
        forever begin
            @(negedge i_clk);
            if (mode_left == 0) begin
                gappy     = $urandom_range(0, 2) != 0;
                mode_left = 400;
            end
            mode_left--;
            if (hold_req) begin
                hold_req = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else if (gappy && !src_quiet && $urandom_range(0, 11) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(0, 9)) @(negedge i_clk);
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    task automatic drive_beat(input logic act, input logic [pctd_pkg::SYM_W-1:0] sym,
                              input logic [pctd_pkg::CODE_W-1:0] code,
                              input logic [pctd_pkg::LEN_W-1:0] len, input logic cbit);
        if (src_gappy && !src_quiet && $urandom_range(0, 3) == 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat ($urandom_range(0, 9)) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid       <= 1'b1;
        i_action      <= act;
        i_load_symbol <= sym;
        i_load_code   <= code;
        i_load_length <= len;
        i_code_bit    <= cbit;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_beat(act, sym, code, len, cbit);
        beats_sent++;
        if (beats_sent % 64 == 0) src_gappy = $urandom_range(0, 2) != 0;
    endtask

    task automatic push_bit(input logic b);
        drive_beat(pctd_pkg::ACT_BIT, 8'($urandom), $urandom, 6'($urandom), b);
    endtask

    task automatic push_load(input logic [pctd_pkg::SYM_W-1:0] sym,
                             input logic [pctd_pkg::CODE_W-1:0] code,
                             input logic [pctd_pkg::LEN_W-1:0] len);
        drive_beat(pctd_pkg::ACT_LOAD, sym, code, len, 1'($urandom));
    endtask

    task automatic load_random();
        logic [pctd_pkg::LEN_W-1:0] n;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 80)      n = 6'($urandom_range(5, 12));
        else if (pick < 93) n = 6'($urandom_range(13, 32));
        else if (pick < 96) n = 6'd0;
        else                n = 6'($urandom_range(33, 63));
        push_load(8'($urandom), $urandom, n);
    endtask

    // stream the bits of a stored code, first bit first, or random bits when no entry fits
    task automatic send_code();
        int k;
        logic [pctd_pkg::LEN_W-1:0]  n;
        logic [pctd_pkg::CODE_W-1:0] c;
        n = '0;
        c = '0;
        if (sb.fill != 0) begin
            k = $urandom_range(0, sb.fill - 1);
            n = sb.len_tab[k];
            c = sb.code_tab[k];
        end
        if (n == 0 || n > MAX_BITS) begin
            repeat ($urandom_range(1, 12)) push_bit(1'($urandom));
        end else begin
            for (int i = int'(n) - 1; i >= 0; i--) push_bit(c[i]);
        end
    endtask

    initial begin
        sb = new(TABLE_SIZE, MAX_BITS);
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        repeat (MAX_BITS) push_bit(1'($urandom));
        push_load(8'h00, 32'hFFFF_FFFE, 6'd2);
        push_load(8'hFF, 32'hFFFF_FFFF, 6'd32);
        push_load(8'h41, 32'h0000_0000, 6'd0);
        push_load(8'h42, 32'hFFFF_FFFF, 6'd63);
        push_load(8'h43, 32'h8000_0002, 6'd2);
        push_bit(1'b1);
        push_load(8'h5A, 32'hFFFF_FFE3, 6'd5);
        push_bit(1'b0);
        repeat (MAX_BITS) push_bit(1'b1);
        push_bit(1'b0);
        push_bit(1'b0);
        push_bit(1'b0);
        push_bit(1'b1);
        push_bit(1'b1);

        while (beats_sent < TOTAL_BEATS - TAIL_BEATS) begin
            if (beats_sent >= PRESSURE_AT && !pressure_done) begin
                hold_req      = 1'b1;
                pressure_done = 1'b1;
            end
            if ($urandom_range(0, 1) == 0) repeat ($urandom_range(1, 8)) load_random();
            repeat ($urandom_range(2, 6)) begin
                if ($urandom_range(0, 9) == 0)
                    repeat ($urandom_range(1, 40)) push_bit(1'($urandom));
                else
                    send_code();
            end
        end

        src_quiet = 1'b1;
        while (sb.fill < TABLE_SIZE - 1) load_random();
        push_load(8'($urandom), $urandom, 6'd1);
        repeat (3) push_load(8'($urandom), $urandom, 6'($urandom));
        while (beats_sent < TOTAL_BEATS) send_code();

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
